// File: rtl/cfsd_pkg.sv
// shared types and constants for the frame deframer
// frame layout positions, checksum seed and the result record
// no dependencies
package cfsd_pkg;

    localparam int unsigned POS_W = 7;

    localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = 7'd4;
    localparam logic [POS_W-1:0] POS_LENGTH_CODE   = 7'd68;
    localparam logic [POS_W-1:0] POS_CONTROL       = 7'd69;
    localparam logic [POS_W-1:0] POS_NANO_FIRST    = 7'd74;
    localparam logic [POS_W-1:0] POS_USER_FIRST    = 7'd78;
    localparam logic [POS_W-1:0] POS_SUM_LIMIT     = 7'd82;
    localparam logic [POS_W-1:0] POS_FRAME_LAST    = 7'd85;

    localparam logic [31:0] SUM_SEED = 32'h5A5A_5A5A;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  data_index;
        logic [7:0]  data_byte;
        logic [31:0] identifier;
        logic [7:0]  length_code;
        logic [7:0]  control;
        logic [31:0] seconds;
        logic [31:0] nanoseconds;
        logic [31:0] user_word;
        logic        checksum_ok;
        logic        last;
    } t_result;

    // little-endian capture: newest byte enters at the top
    function automatic logic [31:0] shift_in(input logic [31:0] word, input logic [7:0] b);
        return {b, word[31:8]};
    endfunction

endpackage

// File: rtl/cfsd_frame_tracker.sv
// frame position counter, running checksum and header field capture
// builds the result for the byte at hand; depends on cfsd_pkg
module cfsd_frame_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_commit,
    input  logic [7:0]        i_byte,
    output logic              o_has_result,
    output cfsd_pkg::t_result o_result
);
    import cfsd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_sum, n_sum;
    logic [31:0]      r_ident, n_ident;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [31:0]      r_sec, n_sec;
    logic [31:0]      r_nsec, n_nsec;
    logic [31:0]      r_user, n_user;
    logic [31:0]      r_marker, n_marker;
    logic [POS_W-1:0] data_offset;

    assign data_offset = r_pos - POS_PAYLOAD_FIRST;

    always_comb begin
        n_pos    = r_pos + 7'd1;
        n_sum    = r_sum;
        n_ident  = r_ident;
        n_len    = r_len;
        n_ctrl   = r_ctrl;
        n_sec    = r_sec;
        n_nsec   = r_nsec;
        n_user   = r_user;
        n_marker = r_marker;
        o_has_result = 1'b0;
        o_result = '0;

        if (r_pos < POS_SUM_LIMIT) begin
            n_sum = r_sum + {24'd0, i_byte};
        end

        if (r_pos < POS_PAYLOAD_FIRST) begin
            n_ident = shift_in(r_ident, i_byte);
        end else if (r_pos < POS_LENGTH_CODE) begin
            o_has_result        = 1'b1;
            o_result.kind       = KIND_DATA;
            o_result.data_index = data_offset[5:0];
            o_result.data_byte  = i_byte;
        end else if (r_pos == POS_LENGTH_CODE) begin
            n_len = i_byte;
        end else if (r_pos == POS_CONTROL) begin
            n_ctrl = i_byte;
        end else if (r_pos < POS_NANO_FIRST) begin
            n_sec = shift_in(r_sec, i_byte);
        end else if (r_pos < POS_USER_FIRST) begin
            n_nsec = shift_in(r_nsec, i_byte);
        end else if (r_pos < POS_SUM_LIMIT) begin
            n_user = shift_in(r_user, i_byte);
        end else begin
            n_marker = shift_in(r_marker, i_byte);
        end

        // last marker byte closes the frame
        if (r_pos >= POS_FRAME_LAST) begin
            o_has_result         = 1'b1;
            o_result             = '0;
            o_result.kind        = KIND_SUMMARY;
            o_result.identifier  = r_ident;
            o_result.length_code = r_len;
            o_result.control     = r_ctrl;
            o_result.seconds     = r_sec;
            o_result.nanoseconds = r_nsec;
            o_result.user_word   = r_user;
            o_result.checksum_ok = (r_sum == n_marker);
            o_result.last        = 1'b1;
            n_pos = '0;
            n_sum = SUM_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= SUM_SEED;
            r_ident  <= '0;
            r_len    <= '0;
            r_ctrl   <= '0;
            r_sec    <= '0;
            r_nsec   <= '0;
            r_user   <= '0;
            r_marker <= '0;
        end else if (i_commit) begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_ident  <= n_ident;
            r_len    <= n_len;
            r_ctrl   <= n_ctrl;
            r_sec    <= n_sec;
            r_nsec   <= n_nsec;
            r_user   <= n_user;
            r_marker <= n_marker;
        end
    end

endmodule

// File: rtl/can_frame_serial_deframer_unit.sv
// top level of the serial frame deframer: input register, frame tracker, result register
// depends on cfsd_pkg and cfsd_frame_tracker
//
// Cuts a stream of received bytes into fixed 86-byte frames by counting alone. Layout,
// multi-byte fields little-endian: identifier (0..3), 64 data bytes (4..67), length code
// (68), control (69), seconds (70..73), nanoseconds (74..77), user word (78..81) and a
// 32-bit marker (82..85). Each data byte leaves at once as a kind-0 transaction with its
// index; the last marker byte yields one kind-1 summary transaction carrying the header
// fields, last = 1 and checksum_ok, which is set when the 32-bit wrapping sum of bytes
// 0..81 seeded with 0x5A5A5A5A equals the marker. Unused fields read 0. The consumer drops
// a frame whose summary shows checksum_ok = 0. There is no resynchronization: a lost or
// extra byte shifts every later frame. Rate: one byte per cycle unless the output stalls;
// a byte passes the input register, then the result register, and the 32-bit add of the
// running sum and the 32-bit marker compare are the deepest logic between them. Header
// bytes and the first three marker bytes produce no transaction and never wait on a
// stalled output; data bytes and the last marker byte wait while a stalled result is held.
module can_frame_serial_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [5:0]  o_data_index,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_identifier,
    output logic [7:0]  o_length_code,
    output logic [7:0]  o_control,
    output logic [31:0] o_seconds,
    output logic [31:0] o_nanoseconds,
    output logic [31:0] o_user_word,
    output logic        o_checksum_ok,
    output logic        o_last
);
    import cfsd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    has_result;
    t_result result;
    logic    out_free;
    logic    in_adv;

    cfsd_frame_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (in_adv),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // result register can take a new transaction this cycle
    assign out_free = !r_out_valid || !i_stall;
    // a byte without a result never waits
    assign in_adv   = r_in_valid && (!has_result || out_free);
    assign o_stall  = r_in_valid && !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && has_result) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_data_index  = r_out.data_index;
    assign o_data_byte   = r_out.data_byte;
    assign o_identifier  = r_out.identifier;
    assign o_length_code = r_out.length_code;
    assign o_control     = r_out.control;
    assign o_seconds     = r_out.seconds;
    assign o_nanoseconds = r_out.nanoseconds;
    assign o_user_word   = r_out.user_word;
    assign o_checksum_ok = r_out.checksum_ok;
    assign o_last        = r_out.last;

endmodule
